/* rtl/blend_qs_transform_nlerp_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bone blend core
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BLEND_QS_TRANSFORM_NLERP_CORE_MACROS_SVH
`define BLEND_QS_TRANSFORM_NLERP_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BQN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("bqn assertion failed");
// next-cycle implication
`define BQN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bqn assertion failed");
`else
`define BQN_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BQN_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/bqn_pkg.sv */
// ----------------------------------------------------------------------------
// bqn_pkg
// Shared constants and types of the bone blend core.
// ----------------------------------------------------------------------------
`default_nettype none
package bqn_pkg;
  localparam int unsigned QLANES   = 4;
  localparam int unsigned VLANES   = 3;
  localparam int unsigned QMAG_W   = 22;  // |q| <= 2^21
  localparam int unsigned N2_W     = 46;  // sum of four q^2
  localparam int unsigned ROOT_W   = 31;  // isqrt(n2 << 16)
  localparam int unsigned SQ_W     = 62;  // radicand width
  localparam int unsigned SQ_STEPS = 31;  // one root bit per stage
  localparam int unsigned QUO_W    = 16;  // quotient bits per lane
  localparam int unsigned REM_W    = 48;  // divider remainder

  localparam logic [16:0]     WEIGHT_ONE  = 17'h10000;
  localparam logic [N2_W-1:0] DEGEN_LIMIT = 46'd4096;
  localparam logic [15:0]     LANE_MAX    = 16'h7fff;

  typedef logic [QLANES-1:0][QMAG_W-1:0] qmag_t;

  // data that rides along the root and divide stages
  typedef struct packed {
    logic [62:0]       trans;
    logic [62:0]       scale;
    logic              degen;
    logic [QLANES-1:0] neg;
  } side_t;

  typedef struct packed {
    qmag_t mag;
    side_t side;
  } sq_side_t;

  // front end result
  typedef struct packed {
    logic              valid;
    logic              degen;
    logic [QLANES-1:0] neg;
    qmag_t             mag;
    logic [N2_W-1:0]   n2;
  } front_t;
endpackage
`default_nettype wire

/* rtl/bqn_in_if.sv */
// ----------------------------------------------------------------------------
// bqn_in_if
// Input channel: one bone pair and a blend weight per item.
// ----------------------------------------------------------------------------
`default_nettype none
interface bqn_in_if;
  logic        valid;
  logic        ready;
  logic [62:0] trans_a;
  logic [62:0] trans_b;
  logic [63:0] rot_a;
  logic [63:0] rot_b;
  logic [62:0] scale_a;
  logic [62:0] scale_b;
  logic [16:0] blend_weight;

  modport source (output valid, trans_a, trans_b, rot_a, rot_b, scale_a, scale_b,
                  blend_weight, input ready);
  modport sink (input valid, trans_a, trans_b, rot_a, rot_b, scale_a, scale_b,
                blend_weight, output ready);
endinterface
`default_nettype wire

/* rtl/bqn_out_if.sv */
// ----------------------------------------------------------------------------
// bqn_out_if
// Output channel: one blended bone per item.
// ----------------------------------------------------------------------------
`default_nettype none
interface bqn_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] trans_out;
  logic [63:0] rot_out;
  logic [62:0] scale_out;
  logic        rot_degenerate;

  modport source (output valid, trans_out, rot_out, scale_out, rot_degenerate,
                  input ready);
  modport sink (input valid, trans_out, rot_out, scale_out, rot_degenerate,
                output ready);
endinterface
`default_nettype wire

/* rtl/bqn_delay.sv */
// ----------------------------------------------------------------------------
// bqn_delay
// Enabled shift line that keeps side data in step with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module bqn_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);
  logic [W-1:0] tap_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[N-1];
endmodule
`default_nettype wire

/* rtl/bqn_vec.sv */
// ----------------------------------------------------------------------------
// bqn_vec
// Linear blend of three packed signed lanes, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module bqn_vec #(
  parameter int unsigned LANE_W = 21
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [62:0] a_i,
  input  wire logic [62:0] b_i,
  input  wire logic [16:0] w_i,
  output logic      [62:0] r_o
);
  localparam int unsigned NV = bqn_pkg::VLANES;
  localparam int unsigned PW = LANE_W + 18;
  localparam logic [LANE_W-1:0] SBIT = {1'b1, {(LANE_W-1){1'b0}}};

  logic [16:0]          wc;
  logic [NV-1:0][PW-1:0] pa_d, pb_d, pa_q, pb_q;
  logic [62:0]          r_d, r_q;

  // stage 1: lane products in offset binary
  assign wc = bqn_pkg::WEIGHT_ONE - w_i;
  always_comb begin
    for (int i = 0; i < NV; i++) begin
      pa_d[i] = PW'(a_i[i*LANE_W +: LANE_W] ^ SBIT) * PW'(wc);
      pb_d[i] = PW'(b_i[i*LANE_W +: LANE_W] ^ SBIT) * PW'(w_i);
    end
  end

  // stage 2: sum, round half up, back to two's complement
  always_comb begin
    logic [PW-1:0] sum;
    r_d = '0;
    for (int i = 0; i < NV; i++) begin
      sum = pa_q[i] + pb_q[i] + PW'(32768);
      r_d[i*LANE_W +: LANE_W] = sum[16 +: LANE_W] ^ SBIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      r_q  <= r_d;
    end
  end

  assign r_o = r_q;
endmodule
`default_nettype wire

/* rtl/bqn_front.sv */
// ----------------------------------------------------------------------------
// bqn_front
// Rotation front end: dot product, shortest-path lerp, rounding, norm square.
// ----------------------------------------------------------------------------
`default_nettype none
module bqn_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [63:0]           rot_a_i,
  input  wire logic [63:0]           rot_b_i,
  input  wire logic [16:0]           w_i,
  output bqn_pkg::front_t            front_o
);
  localparam int unsigned NL = bqn_pkg::QLANES;

  logic [5:0] v_q;

  logic signed [15:0] la1_d [NL], lb1_d [NL], la1_q [NL], lb1_q [NL];
  logic signed [31:0] pd1_d [NL], pd1_q [NL];
  logic [16:0]        w1_q, w2_q;
  logic signed [15:0] la2_q [NL], lb2_q [NL];
  logic signed [33:0] dot2_d;
  logic               neg2_q;
  logic signed [34:0] pa3_d [NL], pb3_d [NL], pa3_q [NL], pb3_q [NL];
  logic signed [22:0] q4_d [NL], q4_q [NL];
  bqn_pkg::qmag_t     mag5_d, mag5_q, mag6_q;
  logic [NL-1:0]      sgn5_d, sgn5_q, sgn6_q;
  logic [NL-1:0][43:0] sq5_d, sq5_q;
  logic [bqn_pkg::N2_W-1:0] n2_d, n2_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  // stage 1: unpack lanes, lane products for the dot
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      la1_d[i] = $signed(rot_a_i[16*i +: 16]);
      lb1_d[i] = $signed(rot_b_i[16*i +: 16]);
      pd1_d[i] = la1_d[i] * lb1_d[i];
    end
  end

  // stage 2: dot sign picks the short path
  assign dot2_d = pd1_q[0] + pd1_q[1] + pd1_q[2] + pd1_q[3];

  // stage 3: weighted lanes
  always_comb begin
    logic [16:0]        wc;
    logic signed [17:0] wcs, ws;
    logic signed [16:0] bb;
    wc  = bqn_pkg::WEIGHT_ONE - w2_q;
    wcs = $signed({1'b0, wc});
    ws  = $signed({1'b0, w2_q});
    for (int i = 0; i < NL; i++) begin
      bb = lb2_q[i];
      if (neg2_q) begin
        bb = -bb;
      end
      pa3_d[i] = la2_q[i] * wcs;
      pb3_d[i] = bb * ws;
    end
  end

  // stage 4: sum, round half up to 6 extra fraction bits
  always_comb begin
    logic signed [35:0] sum;
    for (int i = 0; i < NL; i++) begin
      sum     = pa3_q[i] + pb3_q[i] + 36'sd512;
      q4_d[i] = sum[32:10];
    end
  end

  // stage 5: magnitude and square
  always_comb begin
    logic signed [22:0] qa;
    for (int i = 0; i < NL; i++) begin
      sgn5_d[i] = q4_q[i][22];
      qa        = sgn5_d[i] ? -q4_q[i] : q4_q[i];
      mag5_d[i] = qa[21:0];
      sq5_d[i]  = mag5_d[i] * mag5_d[i];
    end
  end

  // stage 6: squared norm
  assign n2_d = bqn_pkg::N2_W'(sq5_q[0]) + bqn_pkg::N2_W'(sq5_q[1])
              + bqn_pkg::N2_W'(sq5_q[2]) + bqn_pkg::N2_W'(sq5_q[3]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      la1_q  <= la1_d;
      lb1_q  <= lb1_d;
      pd1_q  <= pd1_d;
      w1_q   <= w_i;
      la2_q  <= la1_q;
      lb2_q  <= lb1_q;
      w2_q   <= w1_q;
      neg2_q <= dot2_d[33];
      pa3_q  <= pa3_d;
      pb3_q  <= pb3_d;
      q4_q   <= q4_d;
      mag5_q <= mag5_d;
      sgn5_q <= sgn5_d;
      sq5_q  <= sq5_d;
      mag6_q <= mag5_q;
      sgn6_q <= sgn5_q;
      n2_q   <= n2_d;
    end
  end

  always_comb begin
    front_o.valid = v_q[5];
    front_o.degen = n2_q < bqn_pkg::DEGEN_LIMIT;
    front_o.neg   = sgn6_q;
    front_o.mag   = mag6_q;
    front_o.n2    = n2_q;
  end
endmodule
`default_nettype wire

/* rtl/bqn_isqrt.sv */
// ----------------------------------------------------------------------------
// bqn_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module bqn_isqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [bqn_pkg::SQ_W-1:0]       x_i,
  input  wire logic [SIDE_W-1:0]              side_i,
  output logic                                valid_o,
  output logic      [bqn_pkg::ROOT_W-1:0]     root_o,
  output logic      [SIDE_W-1:0]              side_o
);
  localparam int unsigned ST = bqn_pkg::SQ_STEPS;
  localparam int unsigned XW = bqn_pkg::SQ_W;

  logic [ST-1:0]     v_q;
  logic [XW-1:0]     n_q    [ST-1];
  logic [XW-1:0]     r_q    [ST];
  logic [SIDE_W-1:0] side_q [ST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[ST-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < ST; j++) begin : g_step
    localparam int unsigned K = ST - 1 - j;
    localparam logic [XW-1:0] BIT = XW'(1) << (2 * K);
    logic [XW-1:0]     n_in, r_in, trial, n_d, r_d;
    logic [SIDE_W-1:0] side_in;

    if (j == 0) begin : g_first
      assign n_in    = x_i;
      assign r_in    = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign n_in    = n_q[j-1];
      assign r_in    = r_q[j-1];
      assign side_in = side_q[j-1];
    end

    // trial subtract of the next root bit
    always_comb begin
      trial = r_in + BIT;
      if (n_in >= trial) begin
        n_d = n_in - trial;
        r_d = (r_in >> 1) + BIT;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]    <= r_d;
        side_q[j] <= side_in;
      end
    end

    if (j < ST - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          n_q[j] <= n_d;
        end
      end
    end
  end

  assign valid_o = v_q[ST-1];
  assign root_o  = r_q[ST-1][bqn_pkg::ROOT_W-1:0];
  assign side_o  = side_q[ST-1];
endmodule
`default_nettype wire

/* rtl/bqn_div.sv */
// ----------------------------------------------------------------------------
// bqn_div
// Four-lane pipelined restoring divider: lane = round(|q| * 2^(F+8) / s).
// ----------------------------------------------------------------------------
`default_nettype none
module bqn_div #(
  parameter int unsigned FRAC   = 14,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      en_i,
  input  wire logic                                      valid_i,
  input  wire logic [bqn_pkg::ROOT_W-1:0]                s_i,
  input  wire bqn_pkg::qmag_t                            mag_i,
  input  wire logic [SIDE_W-1:0]                         side_i,
  output logic                                           valid_o,
  output logic      [bqn_pkg::QLANES-1:0][bqn_pkg::QUO_W-1:0] quo_o,
  output logic      [SIDE_W-1:0]                         side_o
);
  localparam int unsigned NL = bqn_pkg::QLANES;
  localparam int unsigned QW = bqn_pkg::QUO_W;
  localparam int unsigned RW = bqn_pkg::REM_W;
  localparam int unsigned SW = bqn_pkg::ROOT_W;

  logic [QW:0]               v_q;
  logic [NL-1:0][RW-1:0]     prem_d, prem_q;
  logic [SW-1:0]             ps_q;
  logic [SIDE_W-1:0]         pside_q;
  logic [NL-1:0][RW-1:0]     rem_q  [QW-1];
  logic [SW-1:0]             s_q    [QW-1];
  logic [NL-1:0][QW-1:0]     quo_q  [QW];
  logic [SIDE_W-1:0]         side_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-1:0], valid_i};
    end
  end

  // prep: scaled numerator plus half divisor for rounding
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      prem_d[i] = (RW'(mag_i[i]) << (FRAC + 8)) + RW'(s_i >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prem_q  <= prem_d;
      ps_q    <= s_i;
      pside_q <= side_i;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int unsigned K = QW - 1 - j;
    logic [NL-1:0][RW-1:0] rem_in, rem_d;
    logic [NL-1:0][QW-1:0] quo_in, quo_d;
    logic [SW-1:0]         s_in;
    logic [SIDE_W-1:0]     side_in;
    logic [RW-1:0]         dv;

    if (j == 0) begin : g_first
      assign rem_in  = prem_q;
      assign quo_in  = '0;
      assign s_in    = ps_q;
      assign side_in = pside_q;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign s_in    = s_q[j-1];
      assign side_in = side_q[j-1];
    end

    // one quotient bit per lane
    always_comb begin
      dv = RW'(s_in) << K;
      for (int i = 0; i < NL; i++) begin
        if (rem_in[i] >= dv) begin
          rem_d[i] = rem_in[i] - dv;
          quo_d[i] = {quo_in[i][QW-2:0], 1'b1};
        end else begin
          rem_d[i] = rem_in[i];
          quo_d[i] = {quo_in[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j]  <= quo_d;
        side_q[j] <= side_in;
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= rem_d;
          s_q[j]   <= s_in;
        end
      end
    end
  end

  assign valid_o = v_q[QW];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];
endmodule
`default_nettype wire

/* rtl/blend_qs_transform_nlerp_core.sv */
// Pipeline: 6 front end stages, 31 square root stages, 17 divider stages;
//   vector lanes travel alongside.
// Throughput: one item per cycle; the whole pipeline advances on one enable,
//   which holds every stage while a finished item waits at the output.
// Reset: asynchronous, active low; clears the valid bits only.
// ----------------------------------------------------------------------------
// blend_qs_transform_nlerp_core
// Bone transform blend: linear translation/scale, shortest-path nlerp rotation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "blend_qs_transform_nlerp_core_macros.svh"
module blend_qs_transform_nlerp_core #(
  parameter int unsigned QUAT_FRAC_BITS = 14,
  parameter int unsigned VEC_LANE_WIDTH = 21
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bqn_in_if.sink     in_i,
  bqn_out_if.source  out_o
);
  localparam int unsigned NL = bqn_pkg::QLANES;
  localparam logic [63:0] ROT_IDENT = {16'(1 << QUAT_FRAC_BITS), 48'd0};

  logic                                pipe_en;
  logic [16:0]                         w_clamp;
  logic [62:0]                         trans_v, scale_v;
  logic [125:0]                        vec_dly;
  bqn_pkg::front_t                     front;
  bqn_pkg::sq_side_t                   sq_side_in, sq_side_out;
  logic                                sq_valid;
  logic [bqn_pkg::ROOT_W-1:0]          root;
  logic                                dv_valid;
  logic [NL-1:0][bqn_pkg::QUO_W-1:0]   quo;
  bqn_pkg::side_t                      dv_side;
  logic [63:0]                         rot_fmt;

  // global advance: stall only while a result waits at the output
  assign pipe_en  = !dv_valid || out_o.ready;
  assign in_i.ready = pipe_en;

  // weight clamp to one
  assign w_clamp = (in_i.blend_weight > bqn_pkg::WEIGHT_ONE) ? bqn_pkg::WEIGHT_ONE
                                                             : in_i.blend_weight;

  // vector lanes, then aligned with the rotation front end
  bqn_vec #(.LANE_W(VEC_LANE_WIDTH)) u_trans (
    .clk_i, .en_i(pipe_en), .a_i(in_i.trans_a), .b_i(in_i.trans_b),
    .w_i(w_clamp), .r_o(trans_v)
  );

  bqn_vec #(.LANE_W(VEC_LANE_WIDTH)) u_scale (
    .clk_i, .en_i(pipe_en), .a_i(in_i.scale_a), .b_i(in_i.scale_b),
    .w_i(w_clamp), .r_o(scale_v)
  );

  bqn_delay #(.W(126), .N(4)) u_vec_dly (
    .clk_i, .en_i(pipe_en), .d_i({trans_v, scale_v}), .q_o(vec_dly)
  );

  bqn_front u_front (
    .clk_i, .rst_ni, .en_i(pipe_en), .valid_i(in_i.valid),
    .rot_a_i(in_i.rot_a), .rot_b_i(in_i.rot_b), .w_i(w_clamp), .front_o(front)
  );

  always_comb begin
    sq_side_in.mag        = front.mag;
    sq_side_in.side.trans = vec_dly[125:63];
    sq_side_in.side.scale = vec_dly[62:0];
    sq_side_in.side.degen = front.degen;
    sq_side_in.side.neg   = front.neg;
  end

  bqn_isqrt #(.SIDE_W($bits(bqn_pkg::sq_side_t))) u_isqrt (
    .clk_i, .rst_ni, .en_i(pipe_en), .valid_i(front.valid),
    .x_i({front.n2, 16'd0}), .side_i(sq_side_in),
    .valid_o(sq_valid), .root_o(root), .side_o(sq_side_out)
  );

  bqn_div #(.FRAC(QUAT_FRAC_BITS), .SIDE_W($bits(bqn_pkg::side_t))) u_div (
    .clk_i, .rst_ni, .en_i(pipe_en), .valid_i(sq_valid), .s_i(root),
    .mag_i(sq_side_out.mag), .side_i(sq_side_out.side),
    .valid_o(dv_valid), .quo_o(quo), .side_o(dv_side)
  );

  // saturate, restore sign, identity on a vanishing norm
  always_comb begin
    logic [15:0] sat;
    rot_fmt = '0;
    for (int i = 0; i < NL; i++) begin
      sat = (quo[i] > bqn_pkg::LANE_MAX) ? bqn_pkg::LANE_MAX : quo[i];
      rot_fmt[16*i +: 16] = dv_side.neg[i] ? 16'(-sat) : sat;
    end
    if (dv_side.degen) begin
      rot_fmt = ROT_IDENT;
    end
  end

  assign out_o.valid          = dv_valid;
  assign out_o.trans_out      = dv_side.trans;
  assign out_o.scale_out      = dv_side.scale;
  assign out_o.rot_out        = rot_fmt;
  assign out_o.rot_degenerate = dv_side.degen;

  // a stall freezes the front end
  `BQN_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, !pipe_en, $stable(front.valid))
  // refused input only while a result is pending
  `BQN_ASSERT_IMP(a_ready_low, clk_i, rst_ni, !in_i.ready, out_o.valid)
  // a normalized lane never reaches the most negative code
  `BQN_ASSERT_IMP(a_lane_range, clk_i, rst_ni, out_o.valid && !out_o.rot_degenerate, (out_o.rot_out[15:0] != 16'h8000) && (out_o.rot_out[31:16] != 16'h8000) && (out_o.rot_out[47:32] != 16'h8000) && (out_o.rot_out[63:48] != 16'h8000))
endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bone blend core testbench
// Drives bone pairs through the input channel and checks every blended bone
// against a bit-true predictor or a typed result: directed corner rows first,
// then random pairs under three back-pressure profiles and a long output stall.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned QFB        = 14;
  localparam int unsigned VLW        = 21;
  localparam int          CLK_HALF   = 4;
  localparam int          RST_CYCLES = 6;
  localparam int          N_RANDOM   = 680;
  localparam int          DRAIN_WAIT = 80;
  localparam int          STALL_LEN  = 300;
  localparam int          WDOG_LIMIT = 3000;
  localparam logic [63:0] QUAT_ID    = 64'h4000_0000_0000_0000;

  typedef struct {
    logic [62:0] ta, tb;
    logic [63:0] ra, rb;
    logic [62:0] sa, sb;
    logic [16:0] wt;
  } bone_pair_t;

  typedef struct {
    logic [62:0] trans;
    logic [63:0] rot;
    logic [62:0] scale;
    logic        degen;
  } bone_blend_t;

  // one directed row; the expectation is only used when typed is set
  typedef struct {
    bone_pair_t  pair;
    bit          typed;
    bone_blend_t res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  bqn_in_if  in_ch ();
  bqn_out_if out_ch ();

  blend_qs_transform_nlerp_core #(
    .QUAT_FRAC_BITS(QFB),
    .VEC_LANE_WIDTH(VLW)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  bone_blend_t pending_blends[$];
  int          fail_cnt;
  int          n_sent;
  int          n_rcvd;
  int          n_degen;
  int          phase;      // 0: light send gaps, 1: heavy send gaps, 2: no gaps
  bit          stall_req;
  bit          stall_seen;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic logic [62:0] lerp_vec(logic [62:0] a, logic [62:0] b,
                                           longint unsigned w);
    longint unsigned mask, sbit, ua, ub, r;
    logic [62:0]     acc;
    mask = (64'd1 << VLW) - 1;
    sbit = 64'd1 << (VLW - 1);
    acc  = '0;
    for (int i = 0; i < 3; i++) begin
      // offset binary keeps the lerp unsigned
      ua  = ((64'(a) >> (i * VLW)) & mask) ^ sbit;
      ub  = ((64'(b) >> (i * VLW)) & mask) ^ sbit;
      r   = (ua * (64'd65536 - w) + ub * w + 64'd32768) >> 16;
      acc = acc | 63'(((r ^ sbit) & mask) << (i * VLW));
    end
    return acc;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic void nlerp_quat(logic [63:0] a, logic [63:0] b,
                                     longint unsigned w,
                                     output logic [63:0] q_out, output logic degen);
    longint          la[4], lb[4], q[4];
    longint          dot, bb, full;
    longint unsigned n2, s, m, r;
    logic [15:0]     lane;
    dot = 0;
    n2  = 0;
    for (int i = 0; i < 4; i++) begin
      la[i] = longint'($signed(a[16*i +: 16]));
      lb[i] = longint'($signed(b[16*i +: 16]));
      dot   = dot + la[i] * lb[i];
    end
    for (int i = 0; i < 4; i++) begin
      // shortest path: flip B when the dot product is negative
      bb   = (dot < 0) ? -lb[i] : lb[i];
      full = la[i] * longint'(65536 - w) + bb * longint'(w);
      q[i] = (full + 512) >>> 10;
      n2   = n2 + longint'(q[i] * q[i]);
    end
    if (n2 < 64'd4096) begin
      degen = 1'b1;
      q_out = QUAT_ID;
      return;
    end
    degen = 1'b0;
    s     = int_sqrt(n2 << 16);
    q_out = '0;
    for (int i = 0; i < 4; i++) begin
      m    = (q[i] < 0) ? -q[i] : q[i];
      r    = ((m << (QFB + 8)) + (s >> 1)) / s;
      if (r > 64'd32767) r = 64'd32767;
      lane = (q[i] < 0) ? 16'(-r) : 16'(r);
      q_out[16*i +: 16] = lane;
    end
  endfunction

  function automatic bone_blend_t blend_bone(bone_pair_t p);
    bone_blend_t     res;
    longint unsigned w;
    w = (p.wt > bqn_pkg::WEIGHT_ONE) ? 64'(bqn_pkg::WEIGHT_ONE) : 64'(p.wt);
    res.trans = lerp_vec(p.ta, p.tb, w);
    res.scale = lerp_vec(p.sa, p.sb, w);
    nlerp_quat(p.ra, p.rb, w, res.rot, res.degen);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random field sources
  // ---------------------------------------------------------------------------
  function automatic logic [62:0] rand_vec();
    logic [62:0] v;
    v = 63'({$urandom, $urandom});
    return v;
  endfunction

  function automatic logic [63:0] rand_quat(int mode);
    logic [63:0] q;
    for (int i = 0; i < 4; i++) begin
      case (mode)
        0:       q[16*i +: 16] = 16'($signed($urandom_range(0, 40)) - 20);
        1:       q[16*i +: 16] = 16'($signed($urandom_range(0, 32768)) - 16384);
        default: q[16*i +: 16] = 16'($urandom);
      endcase
    end
    return q;
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return bqn_pkg::WEIGHT_ONE;
      2:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic bone_pair_t rand_pair();
    bone_pair_t p;
    int         mode;
    mode = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
    p.ta = rand_vec();
    p.tb = rand_vec();
    p.sa = rand_vec();
    p.sb = rand_vec();
    p.ra = rand_quat(mode);
    p.rb = ($urandom_range(0, 5) == 0) ? ~p.ra + 64'h0001_0001_0001_0001 : rand_quat(mode);
    p.wt = rand_weight();
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_pair(bone_pair_t p, bone_blend_t res);
    int gap_pct;
    gap_pct = (phase == 0) ? 8 : (phase == 1) ? 58 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.trans_a      <= p.ta;
    in_ch.trans_b      <= p.tb;
    in_ch.rot_a        <= p.ra;
    in_ch.rot_b        <= p.rb;
    in_ch.scale_a      <= p.sa;
    in_ch.scale_b      <= p.sb;
    in_ch.blend_weight <= p.wt;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_blends.push_back(res);
    n_sent++;
  endtask

  dir_row_t dir_tab[13];

  initial begin
    bone_pair_t p;

    dir_tab[0]  = '{'{63'd0, 63'd0, 64'd0, 64'd0, 63'd0, 63'd0, 17'd0}, 1'b1,
                    '{63'd0, QUAT_ID, 63'd0, 1'b1}};
    dir_tab[1]  = '{'{{63{1'b1}}, 63'd0, QUAT_ID, QUAT_ID, 63'h2AAA_AAAA_AAAA_AAAA,
                      63'd0, 17'd0}, 1'b1,
                    '{{63{1'b1}}, QUAT_ID, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0}};
    dir_tab[2]  = '{'{63'd0, 63'h4000_0200_0010_0000, QUAT_ID, QUAT_ID, 63'd0,
                      {63{1'b1}}, bqn_pkg::WEIGHT_ONE}, 1'b1,
                    '{63'h4000_0200_0010_0000, QUAT_ID, {63{1'b1}}, 1'b0}};
    // weight above one clamps to B
    dir_tab[3]  = '{'{63'h1234_5678_9ABC_DEF0, 63'h3FFF_FDFF_FFEF_FFFF, QUAT_ID, QUAT_ID,
                      63'd5, 63'h5555_5555_5555_5555, 17'h1FFFF}, 1'b1,
                    '{63'h3FFF_FDFF_FFEF_FFFF, QUAT_ID, 63'h5555_5555_5555_5555, 1'b0}};
    // B zero at full weight gives a zero quaternion
    dir_tab[4]  = '{'{63'd7, 63'd7, QUAT_ID, 64'd0, 63'd9, 63'd9, bqn_pkg::WEIGHT_ONE}, 1'b1,
                    '{63'd7, QUAT_ID, 63'd9, 1'b1}};
    // zero dot product, no flip
    dir_tab[5]  = '{'{63'd0, 63'd0, QUAT_ID, 64'h0000_0000_0000_4000, 63'd0, 63'd0,
                      17'd32768}, 1'b0, '{63'd0, 64'd0, 63'd0, 1'b0}};
    // opposite quaternions: flipped B lands on A
    dir_tab[6]  = '{'{63'd0, 63'd0, QUAT_ID, 64'hC000_0000_0000_0000, 63'd0, 63'd0,
                      17'd32768}, 1'b0, '{63'd0, 64'd0, 63'd0, 1'b0}};
    // most negative lane in B, flipped to +32768
    dir_tab[7]  = '{'{63'd0, 63'd0, QUAT_ID, 64'h8000_0000_0000_0000, 63'd0, 63'd0,
                      17'd40000}, 1'b0, '{63'd0, 64'd0, 63'd0, 1'b0}};
    dir_tab[8]  = '{'{{63{1'b1}}, 63'd0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                      63'd0, {63{1'b1}}, 17'd1}, 1'b0, '{63'd0, 64'd0, 63'd0, 1'b0}};
    dir_tab[9]  = '{'{63'd0, {63{1'b1}}, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                      {63{1'b1}}, 63'd0, 17'd65535}, 1'b0, '{63'd0, 64'd0, 63'd0, 1'b0}};
    dir_tab[10] = '{'{63'h4000_0200_0010_0000, 63'h3FFF_FDFF_FFEF_FFFF,
                      64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_0001_FFFF,
                      63'h3FFF_FDFF_FFEF_FFFF, 63'h4000_0200_0010_0000, 17'd32768},
                    1'b0, '{63'd0, 64'd0, 63'd0, 1'b0}};
    // tiny lanes right at the degenerate threshold
    dir_tab[11] = '{'{63'd0, 63'd0, 64'h0001_0000_0000_0000, 64'h0001_0000_0000_0000,
                      63'd0, 63'd0, 17'd20000}, 1'b0, '{63'd0, 64'd0, 63'd0, 1'b0}};
    dir_tab[12] = '{'{63'd0, 63'd0, 64'h0002_0002_0002_0002, 64'hFFFE_FFFE_FFFE_FFFE,
                      63'd0, 63'd0, 17'd32768}, 1'b0, '{63'd0, 64'd0, 63'd0, 1'b0}};

    fail_cnt   = 0;
    n_sent     = 0;
    n_rcvd     = 0;
    n_degen    = 0;
    phase      = 0;
    stall_req  = 1'b0;
    stall_seen = 1'b0;

    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.trans_a      = '0;
    in_ch.trans_b      = '0;
    in_ch.rot_a        = '0;
    in_ch.rot_b        = '0;
    in_ch.scale_a      = '0;
    in_ch.scale_b      = '0;
    in_ch.blend_weight = '0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (dir_tab[i])
      send_pair(dir_tab[i].pair,
                dir_tab[i].typed ? dir_tab[i].res : blend_bone(dir_tab[i].pair));

    // random pairs over three gap profiles
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 3) phase = 1;
      if (k == 2 * N_RANDOM / 3) begin
        phase     = 2;
        stall_req = 1'b1;
      end
      p = rand_pair();
      send_pair(p, blend_bone(p));
    end
    in_ch.valid <= 1'b0;

    wait (pending_blends.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d bone pairs, checked %0d blends (%0d degenerate rotations).",
             n_sent, n_rcvd, n_degen);
    $display("Covered weight clamp, flips, extremes, and a %0d-cycle output stall.",
             STALL_LEN);
    if (fail_cnt == 0 && stall_seen) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // output side: ready pattern and long stall
  // ---------------------------------------------------------------------------
  initial out_ch.ready = 1'b0;

  always @(posedge clk_i) begin : recv_ready
    int stall_cnt;
    int gap_pct;
    if (stall_req && !stall_seen) begin
      stall_seen = 1'b1;
      for (stall_cnt = 0; stall_cnt < STALL_LEN; stall_cnt++) begin
        out_ch.ready <= 1'b0;
        @(posedge clk_i);
      end
    end
    gap_pct = (phase == 0) ? 58 : (phase == 1) ? 8 : 0;
    out_ch.ready <= rst_ni && ($urandom_range(0, 99) >= gap_pct);
  end

  // checker
  always @(posedge clk_i) begin
    bone_blend_t exp_b;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_rcvd++;
      if (pending_blends.size() == 0) begin
        $error("unexpected blend: trans %h rot %h", out_ch.trans_out, out_ch.rot_out);
        fail_cnt++;
      end else begin
        exp_b = pending_blends.pop_front();
        if (exp_b.degen) n_degen++;
        if (out_ch.trans_out !== exp_b.trans) begin
          $error("trans_out: expected %h, got %h", exp_b.trans, out_ch.trans_out);
          fail_cnt++;
        end
        if (out_ch.rot_out !== exp_b.rot) begin
          $error("rot_out: expected %h, got %h", exp_b.rot, out_ch.rot_out);
          fail_cnt++;
        end
        if (out_ch.scale_out !== exp_b.scale) begin
          $error("scale_out: expected %h, got %h", exp_b.scale, out_ch.scale_out);
          fail_cnt++;
        end
        if (out_ch.rot_degenerate !== exp_b.degen) begin
          $error("rot_degenerate: expected %b, got %b", exp_b.degen, out_ch.rot_degenerate);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: cycles without any item moving on either channel
  always @(posedge clk_i) begin : wdog
    int idle_cnt;
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= WDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", WDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end
endmodule
